// ===== design/latency_ewma_min_max_stats_macros.svh =====
// Assertion macros for the latency statistics block.
// Used by the port checker; needs clk_i and rst_ni in the enclosing scope.
`ifndef LATENCY_EWMA_MIN_MAX_STATS_MACROS_SVH
`define LATENCY_EWMA_MIN_MAX_STATS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LEMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LEMS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lems_pkg.sv =====
// Package for the latency statistics block: word types, constants and the
// controller command and state types. No dependencies.
`default_nettype none

package lems_pkg;

  // Number of modules tracked and the width of a table index.
  localparam int unsigned MODULE_COUNT = 8;
  localparam int unsigned IDX_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
  localparam logic [8:0]  MODULE_LIMIT = 9'(MODULE_COUNT);

  // A latency in microseconds is a 32-bit product divided by 1000, so 23 bits hold it.
  localparam int unsigned LAT_W = 23;

  // Tick to microsecond conversion: multiply by 838, then divide by 1000.
  // The divide is a multiply by ceil(2^38 / 1000) and a shift by 38, exact
  // for every 32-bit dividend.
  localparam logic [31:0] TICK_MUL    = 32'd838;
  localparam int unsigned RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned PROD_W      = 32 + RECIP_W;

  // Running average format and weight.
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned EWMA_SHIFT = 12;

  // Item modes.
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Input word.
  typedef struct packed {
    logic        mode;
    logic [7:0]  module_num;
    logic [31:0] submit_time;
    logic [31:0] now_time;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic             accepted;
    logic [LAT_W-1:0] sample_latency_us;
    logic [15:0]      average_latency_us;
    logic [LAT_W-1:0] minimum_latency_us;
    logic [LAT_W-1:0] maximum_latency_us;
  } out_word_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic scale;
    logic divide;
    logic update;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== design/lems_ctrl.sv =====
// Controller for the latency statistics block: sequences one word through
// scale, divide and update. Depends on lems_pkg.
`default_nettype none

module lems_ctrl
  import lems_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output ctrl_cmd_t      cmd_o,
  output logic           busy_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.divide = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lems_datapath.sv =====
// Datapath for the latency statistics block: conversion multipliers, the
// per-module tables and the result register. Depends on lems_pkg.
`default_nettype none

module lems_datapath
  import lems_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  input  wire in_word_t  item_i,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i,
  output logic           result_valid_o,
  output out_word_t      result_o
);

  // Configuration and tables.
  logic                  enabled_q;
  logic [31:0]           avg_tbl_q [MODULE_COUNT];
  logic [LAT_W-1:0]      min_tbl_q [MODULE_COUNT];
  logic [LAT_W-1:0]      max_tbl_q [MODULE_COUNT];
  logic                  result_valid_q;

  // Per-word working registers.
  logic                  mode_q;
  logic                  accepted_q;
  logic [IDX_W-1:0]      idx_q;
  logic [31:0]           ticks_q;
  logic [31:0]           scaled_q;
  logic [LAT_W-1:0]      sample_q;
  logic [31:0]           avg_q;
  logic [LAT_W-1:0]      min_q;
  logic [LAT_W-1:0]      max_q;
  out_word_t             result_q;

  logic                  accepted_d;
  logic [31:0]           scale_prod;
  logic [PROD_W-1:0]     recip_prod;
  logic [31:0]           sample_ext;
  logic [31:0]           avg_diff;
  logic [31:0]           avg_new;
  logic [LAT_W-1:0]      min_new;
  logic [LAT_W-1:0]      max_new;
  logic                  do_write;
  out_word_t             result_d;

  // A word counts only while collection is on and the module exists.
  assign accepted_d = enabled_q && ({1'b0, item_i.module_num} < MODULE_LIMIT);

  // Ticks times 838, kept modulo 2^32.
  assign scale_prod = ticks_q * TICK_MUL;

  // Divide by 1000 through the reciprocal multiply.
  assign recip_prod = PROD_W'(scaled_q) * PROD_W'(RECIP);

  // Running average: a zero average takes the sample directly.
  assign sample_ext = 32'(sample_q);
  assign avg_diff   = sample_ext - {16'b0, avg_q[31:FRAC_BITS]};
  assign avg_new    = (avg_q == '0) ? {sample_q[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}
                                    : avg_q + (avg_diff << EWMA_SHIFT);

  // Minimum treats zero as empty; maximum takes any larger sample.
  assign min_new = ((min_q == '0) || (sample_q < min_q)) ? sample_q : min_q;
  assign max_new = (sample_q > max_q) ? sample_q : max_q;

  assign do_write = accepted_q && (mode_q == MODE_RECORD);

  // Result word: all zero on reject, stored values on a read, updated values on a record.
  always_comb begin
    result_d = '0;
    if (accepted_q) begin
      result_d.accepted = 1'b1;
      if (do_write) begin
        result_d.sample_latency_us  = sample_q;
        result_d.average_latency_us = avg_new[31:FRAC_BITS];
        result_d.minimum_latency_us = min_new;
        result_d.maximum_latency_us = max_new;
      end else begin
        result_d.average_latency_us = avg_q[31:FRAC_BITS];
        result_d.minimum_latency_us = min_q;
        result_d.maximum_latency_us = max_q;
      end
    end
  end

  // Control state: enable register, tables and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      result_valid_q <= 1'b0;
      for (int i = 0; i < MODULE_COUNT; i++) begin
        avg_tbl_q[i] <= '0;
        min_tbl_q[i] <= '0;
        max_tbl_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      result_valid_q <= cmd_i.update;
      if (cmd_i.update && do_write) begin
        avg_tbl_q[idx_q] <= avg_new;
        min_tbl_q[idx_q] <= min_new;
        max_tbl_q[idx_q] <= max_new;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q     <= item_i.mode;
      accepted_q <= accepted_d;
      idx_q      <= accepted_d ? item_i.module_num[IDX_W-1:0] : '0;
      ticks_q    <= item_i.now_time - item_i.submit_time;
    end
    if (cmd_i.scale) begin
      scaled_q <= scale_prod;
    end
    if (cmd_i.divide) begin
      sample_q <= recip_prod[RECIP_SHIFT +: LAT_W];
      avg_q    <= avg_tbl_q[idx_q];
      min_q    <= min_tbl_q[idx_q];
      max_q    <= max_tbl_q[idx_q];
    end
    if (cmd_i.update) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

// ===== design/latency_ewma_min_max_stats.sv =====
// Per-module transmit latency statistics.
//
// Input: a word is taken at a rising edge with start high and busy low. A
// record word converts now_time - submit_time from ticks to microseconds and
// folds the sample into the module's running average (weight 1/16), minimum
// and maximum; a read word returns the stored figures only.
// Output: one result word per input word, shown on result_o for exactly one
// cycle with result_valid_o high. The receiver cannot stall the block, so the
// word must be taken in that cycle.
// Sequence: the controller steps each word through scale, divide and update;
// result_valid_o is registered from the update step. One word is in flight at
// a time and busy stays high until its result shows, so no new word is taken
// before that; the tick multiplies and table read-modify-write need the steps.
// Configuration: cfg_we_i writes the enable bit; write it only while idle.
// Reset clears the enable bit and all module tables at once.
// Depends on lems_pkg, lems_ctrl and lems_datapath.
`default_nettype none

module latency_ewma_min_max_stats
  import lems_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t item_i,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_wdata_i,
  output logic          result_valid_o,
  output out_word_t     result_o
);

  ctrl_cmd_t cmd;

  // Sequencer.
  lems_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Arithmetic and tables.
  lems_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// ===== design/lems_checker.sv =====
// Port checker for the latency statistics block, bound to the top level.
// Depends on lems_pkg and latency_ewma_min_max_stats_macros.svh.
`default_nettype none
`include "latency_ewma_min_max_stats_macros.svh"

module lems_checker
  import lems_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      result_valid_o,
  input wire out_word_t result_o
);

  // An accepted word raises busy at the accepting edge.
  `LEMS_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "busy not raised after accept")

  // Every accepted word must be followed by its result on result_valid_o.
  `LEMS_ASSERT_IMP(a_result_latency, start && !busy, ##4 result_valid_o, "result late or missing")

  // A result is never shown while a word is still being worked on.
  `LEMS_ASSERT_IMP(a_result_idle, result_valid_o, !busy, "result while busy")

  // A rejected word reports zeros throughout.
  `LEMS_ASSERT_IMP(a_reject_zero, result_valid_o && !result_o.accepted, result_o == '0, "reject not zero")

endmodule

bind latency_ewma_min_max_stats lems_checker u_lems_checker (.*);

`default_nettype wire
